// ===== src/hse_pkg.sv =====
`default_nettype none

package hse_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned MAX_ITEMS   = 64;
  localparam int unsigned IDX_W       = $clog2(MAX_ITEMS);
  localparam int unsigned CNT_W       = $clog2(MAX_ITEMS + 1);
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
    logic                     overflow;
  } out_item_t;

endpackage

`default_nettype wire

// ===== src/hse_front.sv =====
`default_nettype none

module hse_front import hse_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  in_item_t item_i,
  output logic     full_o,
  input  logic     pop_i,
  output in_item_t item_o,
  output logic     empty_o
);

  in_item_t            slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wp_q, wp_d, rp_q, rp_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign item_o  = slot_q[rp_q];

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wp_d = (wp_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rp_d = (rp_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_q + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wp_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/hse_out_queue.sv =====
`default_nettype none

module hse_out_queue import hse_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  out_item_t item_i,
  output logic      full_o,
  input  logic      pop_i,
  output out_item_t item_o,
  output logic      empty_o
);

  out_item_t           slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wp_q, wp_d, rp_q, rp_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign item_o  = slot_q[rp_q];

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wp_d = (wp_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rp_d = (rp_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_q + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wp_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/hse_core.sv =====
`default_nettype none

module hse_core import hse_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_item_i,
  input  logic      in_empty_i,
  output logic      in_pop_o,
  output out_item_t out_item_o,
  output logic      out_push_o,
  input  logic      out_full_i
);

  typedef enum logic [9:0] {
    ST_IDLE      = 10'b00_0000_0001,
    ST_UP_CMP    = 10'b00_0000_0010,
    ST_UP_FIN    = 10'b00_0000_0100,
    ST_SEL_START = 10'b00_0000_1000,
    ST_SEL_TAIL  = 10'b00_0001_0000,
    ST_SEL_ROOT  = 10'b00_0010_0000,
    ST_DN_START  = 10'b00_0100_0000,
    ST_DN_L      = 10'b00_1000_0000,
    ST_DN_R      = 10'b01_0000_0000,
    ST_EMIT      = 10'b10_0000_0000
  } state_e;

  function automatic logic [IDX_W-1:0] parent_idx(input logic [IDX_W-1:0] idx);
    parent_idx = (idx - IDX_W'(1)) >> 1;
  endfunction

  state_e                   state_q, state_d;
  logic signed [DATA_W-1:0] heap_q [MAX_ITEMS];
  logic signed [DATA_W-1:0] rd_q;
  logic signed [DATA_W-1:0] val_q, val_d;
  logic signed [DATA_W-1:0] lft_q, lft_d;
  logic                     last_q, last_d;
  logic [IDX_W-1:0]         pos_q, pos_d;
  logic [IDX_W-1:0]         e_q, e_d;
  logic [CNT_W-1:0]         i_q, i_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic                     drop_q, drop_d;

  logic                     we;
  logic [IDX_W-1:0]         wr_addr, rd_addr;
  logic signed [DATA_W-1:0] wr_data;

  logic [CNT_W-1:0]         sz;
  logic [CNT_W:0]           child, right;
  logic                     has_child, has_right;
  logic [IDX_W-1:0]         up;
  logic signed [DATA_W-1:0] best_val;
  logic [IDX_W-1:0]         best_idx;
  logic                     emit_last;

  assign sz        = i_q - CNT_W'(1);
  assign child     = (CNT_W+1)'({pos_q, 1'b1});
  assign right     = child + (CNT_W+1)'(1);
  assign has_child = child < {1'b0, sz};
  assign has_right = right < {1'b0, sz};
  assign up        = parent_idx(pos_q);
  assign emit_last = (CNT_W'(e_q) + CNT_W'(1)) == cnt_q;

  always_comb begin
    if (state_q == ST_DN_R && lft_q < rd_q) begin
      best_val = rd_q;
      best_idx = right[IDX_W-1:0];
    end else if (state_q == ST_DN_R) begin
      best_val = lft_q;
      best_idx = child[IDX_W-1:0];
    end else begin
      best_val = rd_q;
      best_idx = child[IDX_W-1:0];
    end
  end

  always_comb begin
    state_d    = state_q;
    val_d      = val_q;
    lft_d      = lft_q;
    last_d     = last_q;
    pos_d      = pos_q;
    e_d        = e_q;
    i_d        = i_q;
    cnt_d      = cnt_q;
    drop_d     = drop_q;
    we         = 1'b0;
    wr_addr    = pos_q;
    wr_data    = val_q;
    rd_addr    = '0;
    in_pop_o   = 1'b0;
    out_push_o = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (!in_empty_i) begin
          in_pop_o = 1'b1;
          last_d   = in_item_i.last;
          val_d    = in_item_i.value;
          if (cnt_q < CNT_W'(MAX_ITEMS)) begin
            cnt_d = cnt_q + CNT_W'(1);
            i_d   = cnt_q + CNT_W'(1);
            pos_d = cnt_q[IDX_W-1:0];
            if (cnt_q == '0) begin
              we      = 1'b1;
              wr_addr = '0;
              wr_data = in_item_i.value;
              state_d = in_item_i.last ? ST_SEL_START : ST_IDLE;
            end else begin
              rd_addr = parent_idx(cnt_q[IDX_W-1:0]);
              state_d = ST_UP_CMP;
            end
          end else begin
            drop_d  = 1'b1;
            i_d     = cnt_q;
            state_d = in_item_i.last ? ST_SEL_START : ST_IDLE;
          end
        end
      end
      ST_UP_CMP: begin
        we = 1'b1;
        if (rd_q < val_q) begin
          wr_data = rd_q;
          pos_d   = up;
          if (up == '0) begin
            state_d = ST_UP_FIN;
          end else begin
            rd_addr = parent_idx(up);
          end
        end else begin
          state_d = last_q ? ST_SEL_START : ST_IDLE;
        end
      end
      ST_UP_FIN: begin
        we      = 1'b1;
        state_d = last_q ? ST_SEL_START : ST_IDLE;
      end
      ST_SEL_START: begin
        if (i_q <= CNT_W'(1)) begin
          rd_addr = '0;
          e_d     = '0;
          state_d = ST_EMIT;
        end else begin
          rd_addr = sz[IDX_W-1:0];
          state_d = ST_SEL_TAIL;
        end
      end
      ST_SEL_TAIL: begin
        val_d   = rd_q;
        rd_addr = '0;
        state_d = ST_SEL_ROOT;
      end
      ST_SEL_ROOT: begin
        we      = 1'b1;
        wr_addr = sz[IDX_W-1:0];
        wr_data = rd_q;
        pos_d   = '0;
        state_d = ST_DN_START;
      end
      ST_DN_START: begin
        if (has_child) begin
          rd_addr = child[IDX_W-1:0];
          state_d = ST_DN_L;
        end else begin
          we      = 1'b1;
          i_d     = sz;
          state_d = ST_SEL_START;
        end
      end
      ST_DN_L, ST_DN_R: begin
        if (state_q == ST_DN_L && has_right) begin
          lft_d   = rd_q;
          rd_addr = right[IDX_W-1:0];
          state_d = ST_DN_R;
        end else begin
          we = 1'b1;
          if (val_q < best_val) begin
            wr_data = best_val;
            pos_d   = best_idx;
            state_d = ST_DN_START;
          end else begin
            i_d     = sz;
            state_d = ST_SEL_START;
          end
        end
      end
      ST_EMIT: begin
        rd_addr = e_q;
        if (!out_full_i) begin
          out_push_o = 1'b1;
          if (emit_last) begin
            cnt_d   = '0;
            drop_d  = 1'b0;
            state_d = ST_IDLE;
          end else begin
            e_d     = e_q + IDX_W'(1);
            rd_addr = e_q + IDX_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_item_o.value    = rd_q;
  assign out_item_o.last     = emit_last;
  assign out_item_o.overflow = drop_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      drop_q  <= 1'b0;
      last_q  <= 1'b0;
      i_q     <= '0;
      e_q     <= '0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      drop_q  <= drop_d;
      last_q  <= last_d;
      i_q     <= i_d;
      e_q     <= e_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    lft_q <= lft_d;
  end

  // heap storage, one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      heap_q[wr_addr] <= wr_data;
    end
    rd_q <= heap_q[rd_addr];
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_ITEMS))
    else $error("element count beyond capacity");

  a_dn_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DN_START) |-> (CNT_W'(pos_q) < sz))
    else $error("sift-down position outside shrinking heap");

  a_run_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_push_o && out_item_o.last) |=> (cnt_q == '0 && !drop_q && state_q == ST_IDLE))
    else $error("state not cleared after final item of run");

  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_pop_o |-> (state_q == ST_IDLE && !in_empty_i))
    else $error("input item taken while busy");

endmodule

`default_nettype wire

// ===== src/heap_sort_engine.sv =====
// heap sort engine: collects signed 32-bit items and returns them in ascending order
//
// input channel : push / full, with value_i and last_i; an item is taken when
//                 push is high and full is low. last_i closes the set.
// result channel: empty / pop, with sorted_value_o, last_out_o and overflow_o;
//                 the head item is shown while empty is low and leaves on pop.
// up to 64 items are held; later items of the same set are dropped and every
// result of that run then carries overflow_o.
// a two-item queue sits on each side, so input is taken while results wait.
// insertion: from idle the first item is written and a dropped item discarded;
// others climb one heap level per compare in ST_UP_CMP, ST_UP_FIN writing the root,
// in a heap memory with one write and one registered read port. on last:
// each of n-1 removals moves the root to the tail and sifts the old tail down
// (one read per child); results leave one per cycle while the result queue has room.
// while the result queue is full the engine holds; the input queue fills and
// then raises full.
// reset empties both queues and clears the count and overflow flag; the heap
// memory is not cleared, as entries are always written before they are read.
`default_nettype none

module heap_sort_engine import hse_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push,
  output logic                     full,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic                     last_i,
  output logic                     empty,
  input  logic                     pop,
  output logic signed [DATA_W-1:0] sorted_value_o,
  output logic                     last_out_o,
  output logic                     overflow_o
);

  in_item_t  in_item, core_in;
  out_item_t core_out, out_item;
  logic      in_empty, in_pop, out_push, out_full;

  assign in_item.value = value_i;
  assign in_item.last  = last_i;

  hse_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (in_item),
    .full_o  (full),
    .pop_i   (in_pop),
    .item_o  (core_in),
    .empty_o (in_empty)
  );

  hse_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (core_in),
    .in_empty_i (in_empty),
    .in_pop_o   (in_pop),
    .out_item_o (core_out),
    .out_push_o (out_push),
    .out_full_i (out_full)
  );

  hse_out_queue u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .item_i  (core_out),
    .full_o  (out_full),
    .pop_i   (pop),
    .item_o  (out_item),
    .empty_o (empty)
  );

  assign sorted_value_o = out_item.value;
  assign last_out_o     = out_item.last;
  assign overflow_o     = out_item.overflow;

endmodule

`default_nettype wire
